// ===== sv/cddid_pkg.sv =====
// Shared types and constants for the CD disc ID generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package cddid_pkg;

  // Result queue sizing: covers every beat the pipeline can hold plus slack
  localparam int unsigned RES_DEPTH = 8;
  localparam int unsigned PTR_W     = 3;
  localparam int unsigned CNT_W     = 4;

  // Decimal handling: seconds are split into base-100 pairs
  localparam int unsigned PAIR_W     = 7;
  localparam int unsigned PAIR_SUM_W = 5;
  localparam int unsigned DSUM_W     = 6;
  localparam logic [PAIR_W-1:0] PAIR_BASE = 7'd100;

  localparam int unsigned FRAMES_PER_SEC  = 75;
  localparam int unsigned LEAD_IN_FRAMES  = 150;
  localparam int unsigned LEAD_IN_SECONDS = LEAD_IN_FRAMES / FRAMES_PER_SEC;

  localparam int unsigned TOTAL_W = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned COUNT_W = 8;
  localparam logic [TOTAL_W-1:0] TOTAL_MOD = 8'hff;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hff;

  typedef struct packed {
    logic valid;
    logic leadout;
  } beat_ctl_t;

  typedef struct packed {
    logic [31:0] disc_id;
    logic        bad_order;
    logic        count_overflow;
  } result_t;

  // Digit sum of every two-digit value; codes above 99 never occur
  typedef logic [127:0][PAIR_SUM_W-1:0] pair_sum_tbl_t;

  function automatic pair_sum_tbl_t build_pair_sum_tbl();
    pair_sum_tbl_t t;
    t = '0;
    for (int i = 0; i < 100; i++) begin
      t[i] = PAIR_SUM_W'(i / 10 + i % 10);
    end
    return t;
  endfunction

  localparam pair_sum_tbl_t PAIR_SUM_TBL = build_pair_sum_tbl();

endpackage

`default_nettype wire

// ===== sv/cddid_seconds.sv =====
// Seconds and digit-sum pipeline: frames / 75, split into decimal pairs, pair sums.
// Depends on cddid_pkg; three register stages, one beat per cycle.
`default_nettype none

module cddid_seconds
  import cddid_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 19
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire beat_ctl_t                 src_ctl,
  input  wire logic [OFFSET_BITS-1:0]    src_frames,
  output beat_ctl_t                      dst_ctl,
  output logic      [OFFSET_BITS-7:0]    dst_secs,
  output logic      [DSUM_W-1:0]         dst_dsum
);

  localparam int unsigned SEC_W   = OFFSET_BITS - 6;
  localparam int unsigned TS_W    = SEC_W + 1;
  localparam int unsigned Q100_W  = TS_W - 6;

  // Reciprocal constants, exact for the full operand range
  localparam int unsigned K75     = OFFSET_BITS + 7;
  localparam int unsigned M75_W   = OFFSET_BITS + 1;
  localparam int unsigned P75_W   = 2 * OFFSET_BITS + 1;
  localparam logic [63:0] M75_L   = ((64'd1 << K75) + 64'd74) / 64'd75;
  localparam logic [M75_W-1:0] M75 = M75_W'(M75_L);

  localparam int unsigned K100    = TS_W + 7;
  localparam int unsigned K10K    = TS_W + 14;
  localparam int unsigned MQ_W    = TS_W + 1;
  localparam int unsigned PQ_W    = 2 * TS_W + 1;
  localparam logic [63:0] M100_L  = ((64'd1 << K100) + 64'd99) / 64'd100;
  localparam logic [63:0] M10K_L  = ((64'd1 << K10K) + 64'd9999) / 64'd10000;
  localparam logic [MQ_W-1:0] M100 = MQ_W'(M100_L);
  localparam logic [MQ_W-1:0] M10K = MQ_W'(M10K_L);
  localparam int unsigned EXT_W   = (PQ_W > K10K + PAIR_W) ? PQ_W : K10K + PAIR_W;

  // Stage 1: whole seconds
  beat_ctl_t          s1_ctl_r;
  logic [SEC_W-1:0]   s1_secs_r;
  logic [P75_W-1:0]   prod75;

  // Stage 2: seconds plus lead-in, with quotients by 100 and 10000
  beat_ctl_t          s2_ctl_r;
  logic [SEC_W-1:0]   s2_secs_r;
  logic [TS_W-1:0]    s2_ts_r;
  logic [Q100_W-1:0]  s2_q100_r;
  logic [PAIR_W-1:0]  s2_q10k_r;
  logic [TS_W-1:0]    ts;
  logic [PQ_W-1:0]    prod100;
  logic [PQ_W-1:0]    prod10k;
  logic [EXT_W-1:0]   prod10k_ext;

  // Stage 3: digit sum
  beat_ctl_t          s3_ctl_r;
  logic [SEC_W-1:0]   s3_secs_r;
  logic [DSUM_W-1:0]  s3_dsum_r;
  logic [PAIR_W-1:0]  pair_lo;
  logic [PAIR_W-1:0]  pair_mid;
  logic [DSUM_W-1:0]  dsum;

  assign prod75 = P75_W'(src_frames) * P75_W'(M75);

  assign ts          = TS_W'(s1_secs_r) + TS_W'(LEAD_IN_SECONDS);
  assign prod100     = PQ_W'(ts) * PQ_W'(M100);
  assign prod10k     = PQ_W'(ts) * PQ_W'(M10K);
  assign prod10k_ext = EXT_W'(prod10k);

  // Pair values stay below 100, so 7-bit wrap-around arithmetic is exact
  assign pair_lo  = PAIR_W'(s2_ts_r) - PAIR_W'(PAIR_W'(s2_q100_r) * PAIR_BASE);
  assign pair_mid = PAIR_W'(s2_q100_r) - PAIR_W'(s2_q10k_r * PAIR_BASE);
  assign dsum     = DSUM_W'(PAIR_SUM_TBL[pair_lo]) + DSUM_W'(PAIR_SUM_TBL[pair_mid])
                  + DSUM_W'(PAIR_SUM_TBL[s2_q10k_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
    end else begin
      s1_ctl_r <= src_ctl;
      s2_ctl_r <= s1_ctl_r;
      s3_ctl_r <= s2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_secs_r <= prod75[K75 +: SEC_W];
    s2_secs_r <= s1_secs_r;
    s2_ts_r   <= ts;
    s2_q100_r <= prod100[K100 +: Q100_W];
    s2_q10k_r <= prod10k_ext[K10K +: PAIR_W];
    s3_secs_r <= s2_secs_r;
    s3_dsum_r <= dsum;
  end

  assign dst_ctl  = s3_ctl_r;
  assign dst_secs = s3_secs_r;
  assign dst_dsum = s3_dsum_r;

endmodule

`default_nettype wire

// ===== sv/cddid_accum.sv =====
// Per-disc state: digit total mod 255, first seconds, track count, overflow.
// Depends on cddid_pkg; forms the packed disc ID on a lead-out beat.
`default_nettype none

module cddid_accum
  import cddid_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 19
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire beat_ctl_t               src_ctl,
  input  wire logic [OFFSET_BITS-7:0]  src_secs,
  input  wire logic [DSUM_W-1:0]       src_dsum,
  output logic                         res_push,
  output result_t                      res_data
);

  localparam int unsigned SEC_W = OFFSET_BITS - 6;

  logic [TOTAL_W-1:0] total_r,      total_nxt;
  logic [SEC_W-1:0]   first_r,      first_nxt;
  logic               have_first_r, have_first_nxt;
  logic [COUNT_W-1:0] count_r,      count_nxt;
  logic               ovf_r,        ovf_nxt;

  logic [SEC_W-1:0]   first_eff;
  logic               bad;
  logic [SEC_W-1:0]   diff;
  logic [LEN_W-1:0]   len;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_add;

  assign first_eff = have_first_r ? first_r : src_secs;
  assign bad       = src_secs < first_eff;
  assign diff      = src_secs - first_eff;
  assign len       = bad ? '0 : LEN_W'(diff);

  // Total stays below 255 and a digit sum is small: one subtract reduces it
  assign sum       = (TOTAL_W+1)'(total_r) + (TOTAL_W+1)'(src_dsum);
  assign total_add = (sum >= (TOTAL_W+1)'(TOTAL_MOD)) ?
                     TOTAL_W'(sum - (TOTAL_W+1)'(TOTAL_MOD)) : TOTAL_W'(sum);

  assign res_push                = src_ctl.valid & src_ctl.leadout;
  assign res_data.disc_id        = {total_r, len, count_r};
  assign res_data.bad_order      = bad;
  assign res_data.count_overflow = ovf_r;

  always_comb begin
    total_nxt      = total_r;
    first_nxt      = first_r;
    have_first_nxt = have_first_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    if (src_ctl.valid) begin
      if (src_ctl.leadout) begin
        // close the disc: back to the reset state
        total_nxt      = '0;
        first_nxt      = '0;
        have_first_nxt = 1'b0;
        count_nxt      = '0;
        ovf_nxt        = 1'b0;
      end else begin
        if (!have_first_r) begin
          first_nxt      = src_secs;
          have_first_nxt = 1'b1;
        end
        total_nxt = total_add;
        if (count_r == COUNT_MAX) begin
          ovf_nxt = 1'b1;
        end else begin
          count_nxt = count_r + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r      <= '0;
      first_r      <= '0;
      have_first_r <= 1'b0;
      count_r      <= '0;
      ovf_r        <= 1'b0;
    end else begin
      total_r      <= total_nxt;
      first_r      <= first_nxt;
      have_first_r <= have_first_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cddid_res_fifo.sv =====
// Result queue between the pipeline and the output channel.
// Depends on cddid_pkg; flip-flop storage, head entry drives the output.
`default_nettype none

module cddid_res_fifo
  import cddid_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  input  wire logic    pop,
  output logic         head_valid,
  output result_t      head_data
);

  result_t            mem_r [RES_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r,    cnt_nxt;

  assign head_valid = cnt_r != '0;
  assign head_data  = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
  assign rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
  assign cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cd_disc_id_generator.sv =====
// CD disc ID generator, top level.
// Input register, seconds/digit-sum pipeline, disc state, result queue.
//
// Usage:
//   in_ channel: one beat per table-of-contents entry, in disc order. A
//   track beat carries its start frame; the lead-out beat (in_is_leadout)
//   closes the disc and is the only beat that produces a result.
//   out_ channel: one beat per lead-out: packed disc ID, bad_order (lead-out
//   before first track, length forced to zero) and count_overflow (more
//   than 255 tracks, count held at 255).
// Timing:
//   An accepted lead-out beat passes the input register, divide-by-75,
//   decimal split and digit-sum stages, then the state update writes its
//   result to the result queue. One beat is taken every cycle;
//   in_stall rises only when 8 beats sit between the input register and an
//   untaken result, i.e. when the receiver holds results back for long.
// Reset and stall:
//   rst_n (synchronous) empties pipeline and queue and clears the disc state.
//   While out_stall is high the head result holds; later results wait in
//   the 8-entry queue, and beats are still taken until that could fill.
`default_nettype none

module cd_disc_id_generator
  import cddid_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 19
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [OFFSET_BITS-1:0]  in_frame_offset,
  input  wire logic                    in_is_leadout,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [31:0]                  out_disc_id,
  output logic                         out_bad_order,
  output logic                         out_count_overflow
);

  localparam int unsigned SEC_W = OFFSET_BITS - 6;

  beat_ctl_t              in_ctl_r, in_ctl_nxt;
  logic [OFFSET_BITS-1:0] in_frames_r;
  logic                   accept;

  beat_ctl_t              sec_ctl;
  logic [SEC_W-1:0]       sec_secs;
  logic [DSUM_W-1:0]      sec_dsum;

  logic                   res_push;
  result_t                res_data;
  result_t                head_data;
  logic                   pop;
  logic                   track_done;

  // Beats in flight plus queued results; bounds the queue occupancy
  logic [CNT_W-1:0]       used_r, used_nxt;

  assign in_stall = used_r == CNT_W'(RES_DEPTH);
  assign accept   = in_valid & ~in_stall;
  assign pop      = out_valid & ~out_stall;

  assign in_ctl_nxt.valid   = accept;
  assign in_ctl_nxt.leadout = in_is_leadout;

  // a track beat leaves the pipeline without a result: release its slot
  assign track_done = sec_ctl.valid & ~sec_ctl.leadout;
  assign used_nxt   = used_r + CNT_W'(accept) - CNT_W'(track_done) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ctl_r <= '0;
      used_r   <= '0;
    end else begin
      in_ctl_r <= in_ctl_nxt;
      used_r   <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_frames_r <= in_frame_offset;
  end

  cddid_seconds #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_seconds (
    .clk        (clk),
    .rst_n      (rst_n),
    .src_ctl    (in_ctl_r),
    .src_frames (in_frames_r),
    .dst_ctl    (sec_ctl),
    .dst_secs   (sec_secs),
    .dst_dsum   (sec_dsum)
  );

  cddid_accum #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .src_ctl  (sec_ctl),
    .src_secs (sec_secs),
    .src_dsum (sec_dsum),
    .res_push (res_push),
    .res_data (res_data)
  );

  cddid_res_fifo u_res_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_push),
    .push_data  (res_data),
    .pop        (pop),
    .head_valid (out_valid),
    .head_data  (head_data)
  );

  assign out_disc_id        = head_data.disc_id;
  assign out_bad_order      = head_data.bad_order;
  assign out_count_overflow = head_data.count_overflow;

endmodule

`default_nettype wire

// ===== dv/cd_disc_id_generator_tb.sv =====
// Self-checking testbench for cd_disc_id_generator: TOC beats in, disc IDs out.
// Depends on cddid_pkg (result_t) and the cd_disc_id_generator RTL only.
// Holds its own disc ID predictor and compares every result beat field by field.
`default_nettype none

module cd_disc_id_generator_tb
  import cddid_pkg::*;
();

  localparam int unsigned OFFSET_BITS = 19;
  localparam int unsigned OFFSET_MAX  = (1 << OFFSET_BITS) - 1;
  localparam int unsigned RAND_ITEMS  = 1200;
  localparam int unsigned QUIET_FROM  = 500;
  localparam int unsigned QUIET_TO    = 900;

  typedef struct {
    logic [OFFSET_BITS-1:0] frame;
    logic                   leadout;
    bit                     drain;
  } toc_entry_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [OFFSET_BITS-1:0] in_frame_offset = '0;
  logic                   in_is_leadout = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [31:0]            out_disc_id;
  logic                   out_bad_order;
  logic                   out_count_overflow;

  toc_entry_t  toc_pending[$];
  result_t     disc_ids[$];
  int unsigned n_items = 0;
  int unsigned n_errors = 0;
  int unsigned cyc = 0;

  // Disc state of the predictor
  int unsigned digit_acc = 0;
  int unsigned first_secs = 0;
  bit          first_seen = 1'b0;
  int unsigned tracks = 0;
  bit          tracks_over = 1'b0;

  cd_disc_id_generator #(.OFFSET_BITS(OFFSET_BITS)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_frame_offset   (in_frame_offset),
    .in_is_leadout     (in_is_leadout),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_disc_id       (out_disc_id),
    .out_bad_order     (out_bad_order),
    .out_count_overflow(out_count_overflow)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  function automatic int unsigned digit_sum_of(int unsigned v);
    int unsigned s;
    s = 0;
    for (int k = 0; k < 10; k++) begin
      s += v % 10;
      v /= 10;
    end
    return s;
  endfunction

  // Fold one accepted TOC beat into the disc state; a lead-out yields a disc ID
  function automatic void fold_toc_entry(logic [OFFSET_BITS-1:0] frame, logic leadout);
    int unsigned secs, first, len;
    result_t     r;
    secs = int'(frame) / 75;
    if (!leadout) begin
      if (!first_seen) begin
        first_secs = secs;
        first_seen = 1'b1;
      end
      digit_acc = (digit_acc + digit_sum_of((int'(frame) + 150) / 75)) % 255;
      if (tracks >= 255) tracks_over = 1'b1;
      else tracks++;
    end else begin
      first = first_seen ? first_secs : secs;
      len = (secs >= first) ? secs - first : 0;
      r.disc_id = ((digit_acc % 255) << 24) | ((len & 32'hffff) << 8) | (tracks & 32'hff);
      r.bad_order = (secs < first);
      r.count_overflow = tracks_over;
      disc_ids.push_back(r);
      digit_acc = 0;
      first_secs = 0;
      first_seen = 1'b0;
      tracks = 0;
      tracks_over = 1'b0;
    end
  endfunction

  function automatic bit take_break();
    if (cyc >= QUIET_FROM && cyc < QUIET_TO) return 1'b0;
    return $urandom_range(99) < 6;
  endfunction

  // Driver: predict on every accepted beat, then present the next entry
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        fold_toc_entry(in_frame_offset, in_is_leadout);
      end
      if (!in_valid || !in_stall) begin
        if (toc_pending.size() > 0 && !(toc_pending[0].drain && disc_ids.size() > 0) &&
            !take_break()) begin
          in_valid <= 1'b1;
          in_frame_offset <= toc_pending[0].frame;
          in_is_leadout <= toc_pending[0].leadout;
          void'(toc_pending.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result beat against the oldest disc ID
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (disc_ids.size() == 0) begin
          $error("unexpected result beat: disc_id %h", out_disc_id);
          n_errors++;
        end else begin
          want = disc_ids.pop_front();
          if (out_disc_id !== want.disc_id) begin
            $error("disc_id: expected %h, got %h", want.disc_id, out_disc_id);
            n_errors++;
          end
          if (out_bad_order !== want.bad_order) begin
            $error("bad_order: expected %b, got %b", want.bad_order, out_bad_order);
            n_errors++;
          end
          if (out_count_overflow !== want.count_overflow) begin
            $error("count_overflow: expected %b, got %b", want.count_overflow,
                   out_count_overflow);
            n_errors++;
          end
        end
      end
      out_stall <= take_break();
    end
  end

  task automatic add_entry(int unsigned frame, bit leadout, bit drain);
    toc_entry_t e;
    e.frame = frame[OFFSET_BITS-1:0];
    e.leadout = leadout;
    e.drain = drain;
    toc_pending.push_back(e);
    n_items++;
  endtask

  // Tidy discs have ascending offsets and a lead-out past the last track
  task automatic add_disc(int unsigned ntr, bit tidy, bit drain);
    int unsigned pos, step_max;
    step_max = OFFSET_MAX / (ntr + 2);
    pos = $urandom_range(step_max, 0);
    for (int i = 0; i < ntr; i++) begin
      if (tidy) add_entry(pos, 1'b0, drain && i == 0);
      else add_entry($urandom_range(OFFSET_MAX, 0), 1'b0, drain && i == 0);
      pos += $urandom_range(step_max, 1);
    end
    if (tidy) add_entry(pos, 1'b1, drain && ntr == 0);
    else add_entry($urandom_range(OFFSET_MAX, 0), 1'b1, drain && ntr == 0);
  endtask

  initial begin
    int unsigned n_discs, ntr, r;
    // Lead-out with no tracks, at both ends of the range
    add_entry(0, 1'b1, 1'b0);
    add_entry(OFFSET_MAX, 1'b1, 1'b0);
    // Extremes of the offset, lead-out at the top
    add_entry(0, 1'b0, 1'b0);
    add_entry(OFFSET_MAX, 1'b0, 1'b0);
    add_entry(OFFSET_MAX, 1'b1, 1'b0);
    // Lead-out ahead of the first track: length clamps, bad_order set
    add_entry(300000, 1'b0, 1'b0);
    add_entry(150, 1'b1, 1'b0);
    // Seconds boundaries at multiples of 75 frames; hold until the pipe drains first
    add_entry(74, 1'b0, 1'b1);
    add_entry(75, 1'b0, 1'b0);
    add_entry(224, 1'b0, 1'b0);
    add_entry(225, 1'b1, 1'b0);
    // An ordinary three-track disc
    add_entry(0, 1'b0, 1'b0);
    add_entry(16233, 1'b0, 1'b0);
    add_entry(35112, 1'b0, 1'b0);
    add_entry(198765, 1'b1, 1'b0);
    // Same first and lead-out seconds
    add_entry(100, 1'b0, 1'b0);
    add_entry(120, 1'b1, 1'b0);

    n_items = 0;
    n_discs = 0;
    while (n_items < RAND_ITEMS) begin
      r = $urandom_range(99);
      // Always one disc of 254 to 300 tracks early on, the odd one later
      if (n_discs == 4 || r < 2) ntr = $urandom_range(300, 254);
      else if (r < 10) ntr = 0;
      else ntr = $urandom_range(20, 1);
      add_disc(ntr, $urandom_range(9) != 0, $urandom_range(9) == 0);
      n_discs++;
    end

    do @(posedge clk);
    while (toc_pending.size() != 0 || in_valid || disc_ids.size() != 0);
    repeat (12) @(posedge clk);
    if (n_errors == 0 && disc_ids.size() == 0) begin
      $display("cd_disc_id_generator_tb: clean");
    end else begin
      $display("cd_disc_id_generator_tb: errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("cd_disc_id_generator_tb: errors");
    $finish;
  end

endmodule

`default_nettype wire
